>>> rtl/wavhdr_pkg.sv
package wavhdr_pkg;

	typedef enum logic [8:0] {
		PH_IDLE      = 9'b000000001,
		PH_RIFF_TAG  = 9'b000000010,
		PH_RIFF_SIZE = 9'b000000100,
		PH_WAVE_TAG  = 9'b000001000,
		PH_CHUNK_ID  = 9'b000010000,
		PH_CHUNK_SZ  = 9'b000100000,
		PH_FMT_BODY  = 9'b001000000,
		PH_SKIP      = 9'b010000000,
		PH_DONE      = 9'b100000000
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOT_RIFF = 3'd1,
		ST_NOT_WAVE = 3'd2,
		ST_NOT_PCM  = 3'd3,
		ST_NO_DATA  = 3'd4
	} status_t;

	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;
	localparam logic [31:0] FMT_LEN  = 32'd16;
	localparam logic [15:0] FMT_PCM  = 16'd1;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  pos;
		logic [31:0] tag;
		logic [31:0] size;
		logic [31:0] skip;
		logic [15:0] fmt;
		logic [15:0] chan;
		logic [31:0] rate;
		logic [15:0] bits;
	} parse_state_t;

	localparam parse_state_t PARSE_CLEAR = '{
		phase: PH_IDLE,
		pos:   4'd0,
		tag:   32'd0,
		size:  32'd0,
		skip:  32'd0,
		fmt:   16'd0,
		chan:  16'd0,
		rate:  32'd0,
		bits:  16'd0
	};

	typedef struct packed {
		status_t     status;
		logic [15:0] audio_format;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [15:0] sample_bits;
		logic [31:0] data_size;
	} result_t;

endpackage

>>> rtl/wav_header_parser.sv
// A word is captured in the input register; the parser then steps it and any result
// is registered in the result register. Throughput: one word per cycle; the parse
// step is combinational between the input register and the parser state register,
// and the input side only stalls while a result is held by a stalled output.
// Reset (arst_n low, asynchronous): parser idle awaiting a first-byte mark.
module wav_header_parser
	import wavhdr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  byte_value,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic [15:0] audio_format,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [15:0] sample_bits,
	output logic [31:0] data_size
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         first_s1;
	logic         last_s1;
	parse_state_t state_q;
	parse_state_t state_next;
	logic         emit;
	result_t      result;
	result_t      res_q;
	logic         res_valid_q;
	logic         adv;

	// step the parser when the result slot is free or being emptied
	assign adv        = valid_s1 && (!res_valid_q || !result_stall);
	assign byte_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1  <= byte_value;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
	end

	wavhdr_step u_step (
		.state      (state_q),
		.byte_value (byte_s1),
		.first_byte (first_s1),
		.last_byte  (last_s1),
		.state_next (state_next),
		.emit       (emit),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_CLEAR;
		end else if (adv) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= result;
		end
	end

	assign result_valid  = res_valid_q;
	assign status        = res_q.status;
	assign audio_format  = res_q.audio_format;
	assign channel_count = res_q.channel_count;
	assign sample_rate   = res_q.sample_rate;
	assign sample_bits   = res_q.sample_bits;
	assign data_size     = res_q.data_size;

`ifndef SYNTHESIS
	a_ok_has_data : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_OK |-> data_size != 32'd0)
		else $error("ok result with empty data chunk");

	a_err_zero : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_OK |-> audio_format == 16'd0 &&
			channel_count == 16'd0 && sample_rate == 32'd0 &&
			sample_bits == 16'd0 && data_size == 32'd0)
		else $error("error result carries header fields");

	a_emit_done : assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit |=> state_q.phase == PH_DONE && result_valid)
		else $error("result emitted without parser ending");

	a_skip_pad : assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_SKIP |-> state_q.pos[3:1] == 3'd0)
		else $error("pad flag out of range while skipping");

	a_stall_held : assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && res_valid_q && result_stall)
		else $error("input stalled with free result slot");
`endif

endmodule

>>> rtl/wavhdr_step.sv
module wavhdr_step
	import wavhdr_pkg::*;
(
	input  parse_state_t state,
	input  logic [7:0]   byte_value,
	input  logic         first_byte,
	input  logic         last_byte,
	output parse_state_t state_next,
	output logic         emit,
	output result_t      result
);

	parse_state_t cur;
	parse_state_t nx;
	logic [3:0]   pos_inc;
	logic [31:0]  tag_n;
	logic [31:0]  size_n;
	logic [31:0]  fmt_rest;
	logic         hit;
	logic         ok;
	logic         active;
	status_t      st;

	always_comb begin
		cur = state;
		if (first_byte) begin
			cur = PARSE_CLEAR;
			cur.phase = PH_RIFF_TAG;
		end
		nx       = cur;
		hit      = 1'b0;
		ok       = 1'b0;
		st       = ST_OK;
		pos_inc  = cur.pos + 4'd1;
		tag_n    = {cur.tag[23:0], byte_value};
		size_n   = {byte_value, cur.size[31:8]};
		fmt_rest = cur.size - FMT_LEN;

		unique case (cur.phase)
			PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_ID: begin
				nx.tag = tag_n;
				nx.pos = pos_inc;
				if (pos_inc >= 4'd4) begin
					nx.pos = 4'd0;
					if (cur.phase == PH_RIFF_TAG) begin
						if (tag_n != TAG_RIFF) begin
							hit = 1'b1;
							st  = ST_NOT_RIFF;
						end else begin
							nx.phase = PH_RIFF_SIZE;
						end
					end else if (cur.phase == PH_WAVE_TAG) begin
						if (tag_n != TAG_WAVE) begin
							hit = 1'b1;
							st  = ST_NOT_WAVE;
						end else begin
							nx.phase = PH_CHUNK_ID;
						end
					end else begin
						nx.phase = PH_CHUNK_SZ;
					end
				end
			end
			PH_RIFF_SIZE: begin
				nx.pos = pos_inc;
				if (pos_inc >= 4'd4) begin
					nx.pos   = 4'd0;
					nx.phase = PH_WAVE_TAG;
				end
			end
			PH_CHUNK_SZ: begin
				nx.size = size_n;
				nx.pos  = pos_inc;
				if (pos_inc >= 4'd4) begin
					nx.pos = 4'd0;
					if (cur.tag == TAG_FMT) begin
						nx.phase = PH_FMT_BODY;
					end else if (cur.tag == TAG_DATA) begin
						hit = 1'b1;
						if (size_n == 32'd0) begin
							st = ST_NO_DATA;
						end else begin
							ok = 1'b1;
						end
					end else if (size_n == 32'd0) begin
						nx.phase = PH_CHUNK_ID;
					end else begin
						// odd size leaves a pad byte pending in pos[0]
						nx.phase = PH_SKIP;
						nx.skip  = size_n;
						nx.pos   = {3'd0, size_n[0]};
					end
				end
			end
			PH_FMT_BODY: begin
				unique case (cur.pos)
					4'd0:  nx.fmt[7:0]    = byte_value;
					4'd1:  nx.fmt[15:8]   = byte_value;
					4'd2:  nx.chan[7:0]   = byte_value;
					4'd3:  nx.chan[15:8]  = byte_value;
					4'd4:  nx.rate[7:0]   = byte_value;
					4'd5:  nx.rate[15:8]  = byte_value;
					4'd6:  nx.rate[23:16] = byte_value;
					4'd7:  nx.rate[31:24] = byte_value;
					4'd14: nx.bits[7:0]   = byte_value;
					4'd15: nx.bits[15:8]  = byte_value;
					default: ;
				endcase
				nx.pos = pos_inc;
				if (cur.pos == 4'd15) begin
					nx.pos = 4'd0;
					if (nx.fmt != FMT_PCM) begin
						hit = 1'b1;
						st  = ST_NOT_PCM;
					end else if (cur.size > FMT_LEN) begin
						if (fmt_rest == 32'd0 && !cur.size[0]) begin
							nx.phase = PH_CHUNK_ID;
						end else begin
							nx.phase = PH_SKIP;
							nx.skip  = fmt_rest;
							nx.pos   = {3'd0, cur.size[0]};
						end
					end else begin
						// short fmt: nothing further to skip
						nx.phase = PH_CHUNK_ID;
					end
				end
			end
			PH_SKIP: begin
				if (cur.skip != 32'd0) begin
					nx.skip = cur.skip - 32'd1;
				end else begin
					nx.pos = 4'd0;
				end
				if (nx.skip == 32'd0 && !nx.pos[0]) begin
					nx.pos   = 4'd0;
					nx.phase = PH_CHUNK_ID;
				end
			end
			PH_IDLE, PH_DONE: ;
			default: nx.phase = PH_DONE;
		endcase

		active = cur.phase == PH_RIFF_TAG || cur.phase == PH_RIFF_SIZE ||
			cur.phase == PH_WAVE_TAG || cur.phase == PH_CHUNK_ID ||
			cur.phase == PH_CHUNK_SZ || cur.phase == PH_FMT_BODY ||
			cur.phase == PH_SKIP;

		// file ended before a data chunk
		if (last_byte && active && !hit) begin
			hit = 1'b1;
			ok  = 1'b0;
			st  = ST_NO_DATA;
		end
		if (hit) begin
			nx.phase = PH_DONE;
		end
	end

	assign state_next           = nx;
	assign emit                 = hit;
	assign result.status        = st;
	assign result.audio_format  = ok ? nx.fmt  : 16'd0;
	assign result.channel_count = ok ? nx.chan : 16'd0;
	assign result.sample_rate   = ok ? nx.rate : 32'd0;
	assign result.sample_bits   = ok ? nx.bits : 16'd0;
	assign result.data_size     = ok ? size_n  : 32'd0;

endmodule

>>> sim/wav_header_parser_tb.sv
module wav_header_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wavhdr_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  byte_value = 8'h00;
	logic        first_byte = 1'b0;
	logic        last_byte = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  status;
	logic [15:0] audio_format;
	logic [15:0] channel_count;
	logic [31:0] sample_rate;
	logic [15:0] sample_bits;
	logic [31:0] data_size;

	wav_header_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.byte_value    (byte_value),
		.first_byte    (first_byte),
		.last_byte     (last_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.status        (status),
		.audio_format  (audio_format),
		.channel_count (channel_count),
		.sample_rate   (sample_rate),
		.sample_bits   (sample_bits),
		.data_size     (data_size)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("wav_header_parser test failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// Header predictor
	// ---------------------------------------------------------------
	phase_t      hdr_phase = PH_IDLE;
	int unsigned hdr_pos;
	logic [31:0] hdr_tag, hdr_size, hdr_skip, hdr_rate;
	logic [15:0] hdr_fmt, hdr_chan, hdr_bits;

	result_t awaited_headers[$];

	task automatic clear_parse();
		hdr_phase = PH_IDLE;
		hdr_pos = 0;
		hdr_tag = '0;
		hdr_size = '0;
		hdr_skip = '0;
		hdr_fmt = '0;
		hdr_chan = '0;
		hdr_rate = '0;
		hdr_bits = '0;
	endtask

	task automatic close_parse(input status_t st, output bit got, output result_t res);
		res = '0;
		res.status = st;
		if (st == ST_OK) begin
			res.audio_format = hdr_fmt;
			res.channel_count = hdr_chan;
			res.sample_rate = hdr_rate;
			res.sample_bits = hdr_bits;
			res.data_size = hdr_size;
		end
		got = 1'b1;
		hdr_phase = PH_DONE;
	endtask

	task automatic start_skip(input logic [31:0] count, input logic pad);
		hdr_skip = count;
		hdr_pos = {31'd0, pad};
		if (count == 0 && !pad) begin
			hdr_phase = PH_CHUNK_ID;
			hdr_pos = 0;
		end else begin
			hdr_phase = PH_SKIP;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic fb, input logic lb,
			output bit got, output result_t res);
		int unsigned p;
		got = 1'b0;
		res = '0;
		if (fb) begin
			clear_parse();
			hdr_phase = PH_RIFF_TAG;
		end
		if (hdr_phase == PH_IDLE || hdr_phase == PH_DONE)
			return;
		case (hdr_phase)
			PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_ID: begin
				hdr_tag = {hdr_tag[23:0], b};
				hdr_pos++;
				if (hdr_pos >= 4) begin
					hdr_pos = 0;
					if (hdr_phase == PH_RIFF_TAG) begin
						if (hdr_tag != TAG_RIFF) begin
							close_parse(ST_NOT_RIFF, got, res);
							return;
						end
						hdr_phase = PH_RIFF_SIZE;
					end else if (hdr_phase == PH_WAVE_TAG) begin
						if (hdr_tag != TAG_WAVE) begin
							close_parse(ST_NOT_WAVE, got, res);
							return;
						end
						hdr_phase = PH_CHUNK_ID;
					end else begin
						hdr_phase = PH_CHUNK_SZ;
					end
				end
			end
			PH_RIFF_SIZE: begin
				hdr_pos++;
				if (hdr_pos >= 4) begin
					hdr_pos = 0;
					hdr_phase = PH_WAVE_TAG;
				end
			end
			PH_CHUNK_SZ: begin
				hdr_size = {b, hdr_size[31:8]};
				hdr_pos++;
				if (hdr_pos >= 4) begin
					hdr_pos = 0;
					if (hdr_tag == TAG_FMT) begin
						hdr_phase = PH_FMT_BODY;
					end else if (hdr_tag == TAG_DATA) begin
						close_parse(hdr_size == 0 ? ST_NO_DATA : ST_OK, got, res);
						return;
					end else begin
						start_skip(hdr_size, hdr_size[0]);
					end
				end
			end
			PH_FMT_BODY: begin
				p = hdr_pos & 15;
				case (p)
					0: hdr_fmt[7:0] = b;
					1: hdr_fmt[15:8] = b;
					2: hdr_chan[7:0] = b;
					3: hdr_chan[15:8] = b;
					4, 5, 6, 7: hdr_rate[8*(p-4) +: 8] = b;
					14: hdr_bits[7:0] = b;
					15: hdr_bits[15:8] = b;
					default: ;
				endcase
				hdr_pos = p + 1;
				if (hdr_pos >= FMT_LEN) begin
					hdr_pos = 0;
					if (hdr_fmt != FMT_PCM) begin
						close_parse(ST_NOT_PCM, got, res);
						return;
					end
					if (hdr_size > FMT_LEN)
						start_skip(hdr_size - FMT_LEN, hdr_size[0]);
					else
						hdr_phase = PH_CHUNK_ID;
				end
			end
			PH_SKIP: begin
				if (hdr_skip > 0)
					hdr_skip--;
				else
					hdr_pos = 0;
				if (hdr_skip == 0 && (hdr_pos & 1) == 0) begin
					hdr_pos = 0;
					hdr_phase = PH_CHUNK_ID;
				end
			end
			default: begin
				hdr_phase = PH_DONE;
				return;
			end
		endcase
		if (lb)
			close_parse(ST_NO_DATA, got, res);
	endtask

	// ---------------------------------------------------------------
	// Word driver
	// ---------------------------------------------------------------
	int send_idle_pct = 0;
	int stall_pct = 0;
	int live_words = 0;

	task automatic set_idling(input int mode);
		case (mode)
			1: begin send_idle_pct = 57; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 57; end
			3: begin send_idle_pct = 27; stall_pct = 27; end
			default: begin send_idle_pct = 0; stall_pct = 0; end
		endcase
	endtask

	// called just after a falling edge; returns just after a falling edge once the byte is taken
	task automatic send_byte(input logic [7:0] b, input logic fb, input logic lb,
			input logic typed, input status_t typed_st);
		bit got;
		result_t res;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_value <= b;
		first_byte <= fb;
		last_byte <= lb;
		do @(posedge clk); while (byte_stall);
		if (fb || !(hdr_phase == PH_IDLE || hdr_phase == PH_DONE))
			live_words++;
		parse_byte(b, fb, lb, got, res);
		if (typed) begin
			res = '0;
			res.status = typed_st;
			got = 1'b1;
		end
		if (got)
			awaited_headers.push_back(res);
		@(negedge clk);
	endtask

	always @(negedge clk)
		result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

	// ---------------------------------------------------------------
	// Result checker
	// ---------------------------------------------------------------
	int mismatches = 0;
	int clean_seen = 0;
	int error_seen = 0;

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (status == ST_OK)
				clean_seen++;
			else
				error_seen++;
			if (awaited_headers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with none awaited, status %0d size %h",
						$time, status, data_size);
			end else begin
				want = awaited_headers.pop_front();
				if (status !== want.status || audio_format !== want.audio_format ||
						channel_count !== want.channel_count ||
						sample_rate !== want.sample_rate ||
						sample_bits !== want.sample_bits || data_size !== want.data_size) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: mismatch exp st %0d fmt %h ch %h rate %h bits %h size %h",
							" | got st %0d fmt %h ch %h rate %h bits %h size %h"},
							$time, want.status, want.audio_format, want.channel_count,
							want.sample_rate, want.sample_bits, want.data_size,
							status, audio_format, channel_count, sample_rate,
							sample_bits, data_size);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	typedef struct packed {
		logic [7:0] value;
		logic       fb;
		logic       lb;
		logic       typed;
		status_t    code;
	} stim_row_t;

	// bad RIFF tag, bad WAVE tag, restart mid-file, truncation, ignored words
	stim_row_t dir_rows [0:24] = '{
		'{8'h52, 1'b0, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b1, 1'b0, ST_OK},
		'{8'h52, 1'b1, 1'b0, 1'b0, ST_OK},
		'{8'h49, 1'b0, 1'b0, 1'b0, ST_OK},
		'{8'h46, 1'b0, 1'b0, 1'b0, ST_OK},
		'{8'h58, 1'b0, 1'b0, 1'b1, ST_NOT_RIFF},
		'{8'h46, 1'b0, 1'b1, 1'b0, ST_OK},
		'{8'h52, 1'b1, 1'b0, 1'b0, ST_OK},
		'{8'h49, 1'b0, 1'b0, 1'b0, ST_OK},
		'{8'h46, 1'b0, 1'b0, 1'b0, ST_OK},
		'{8'h46, 1'b0, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
		'{8'h57, 1'b0, 1'b0, 1'b0, ST_OK},
		'{8'h41, 1'b0, 1'b0, 1'b0, ST_OK},
		'{8'h56, 1'b0, 1'b0, 1'b0, ST_OK},
		'{8'h46, 1'b0, 1'b0, 1'b1, ST_NOT_WAVE},
		'{8'h52, 1'b1, 1'b0, 1'b0, ST_OK},
		'{8'h49, 1'b0, 1'b0, 1'b0, ST_OK},
		'{8'h52, 1'b1, 1'b0, 1'b0, ST_OK},
		'{8'h49, 1'b0, 1'b1, 1'b1, ST_NO_DATA},
		'{8'h00, 1'b1, 1'b1, 1'b1, ST_NO_DATA},
		'{8'h5A, 1'b0, 1'b0, 1'b0, ST_OK}
	};

	typedef enum {
		SC_PLAIN, SC_NOT_PCM, SC_DATA_FIRST, SC_MULTI_FMT, SC_SHORT_FMT, SC_ODD_SIZES,
		SC_EMPTY_DATA, SC_TRUNCATED, SC_NO_DATA, SC_BAD_TAG, SC_ABANDONED, SC_RANDOM
	} scenario_t;

	typedef enum {CK_FMT, CK_FMT_SHORT, CK_FMT_LONG, CK_FMT_NOT_PCM, CK_OTHER} chunk_kind_t;

	logic [7:0] file_q[$];

	function automatic logic [31:0] biased32();
		case ($urandom_range(7))
			0: return '1;
			1: return '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic put_tag(input logic [31:0] t);
		for (int i = 3; i >= 0; i--)
			file_q.push_back(t[8*i +: 8]);
	endtask

	task automatic put_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			file_q.push_back(v[8*i +: 8]);
	endtask

	task automatic put_noise(input int n);
		for (int i = 0; i < n; i++)
			file_q.push_back(8'($urandom));
	endtask

	task automatic put_chunk(input chunk_kind_t ck, input bit odd);
		logic [31:0] len;
		logic [15:0] code;
		if (ck == CK_OTHER) begin
			len = $urandom_range(0, 9);
			if (odd)
				len[0] = 1'b1;
			put_tag($urandom);
			put_le(len, 4);
			put_noise(len + len[0]);
			return;
		end
		case (ck)
			CK_FMT_SHORT: len = $urandom_range(0, 15);
			CK_FMT_LONG:  len = $urandom_range(17, 26);
			default:      len = FMT_LEN;
		endcase
		if (odd && len > FMT_LEN)
			len[0] = 1'b1;
		code = FMT_PCM;
		if (ck == CK_FMT_NOT_PCM)
			code = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom_range(2, 65535));
		put_tag(TAG_FMT);
		put_le(len, 4);
		put_le({16'd0, code}, 2);
		put_le(biased32(), 2);
		put_le(biased32(), 4);
		put_noise(6);
		put_le(biased32(), 2);
		// only the part past the 16 format bytes is skipped, plus its pad
		if (len > FMT_LEN)
			put_noise(len - FMT_LEN + len[0]);
	endtask

	task automatic send_file(input scenario_t sc);
		chunk_kind_t plan[$];
		logic [31:0] riff, wave, dsize;
		bit with_data, mark_last, odd;
		int cut;
		riff = TAG_RIFF;
		wave = TAG_WAVE;
		with_data = 1'b1;
		odd = (sc == SC_ODD_SIZES);
		dsize = biased32();
		case (sc)
			SC_NOT_PCM:    plan.push_back(CK_FMT_NOT_PCM);
			SC_DATA_FIRST: plan.push_back(CK_OTHER);
			SC_MULTI_FMT: begin
				plan.push_back(CK_FMT);
				plan.push_back(CK_OTHER);
				plan.push_back(CK_FMT);
			end
			SC_SHORT_FMT:  plan.push_back(CK_FMT_SHORT);
			SC_ODD_SIZES: begin
				plan.push_back(CK_OTHER);
				plan.push_back(CK_FMT_LONG);
			end
			SC_NO_DATA: begin
				plan.push_back(CK_FMT);
				plan.push_back(CK_OTHER);
				with_data = 1'b0;
			end
			SC_RANDOM: begin
				odd = 1'($urandom_range(1));
				for (int i = $urandom_range(0, 3); i > 0; i--)
					case ($urandom_range(9))
						0, 1, 2, 3: plan.push_back(CK_FMT);
						4: plan.push_back(CK_FMT_SHORT);
						5: plan.push_back(CK_FMT_LONG);
						6: plan.push_back(CK_FMT_NOT_PCM);
						default: plan.push_back(CK_OTHER);
					endcase
				case ($urandom_range(15))
					0: with_data = 1'b0;
					1: dsize = '0;
					default: ;
				endcase
			end
			default: plan.push_back(CK_FMT);
		endcase
		if (sc == SC_EMPTY_DATA)
			dsize = '0;
		if (sc == SC_BAD_TAG) begin
			if ($urandom_range(1))
				riff ^= 32'd1 << $urandom_range(31);
			else
				wave ^= 32'd1 << $urandom_range(31);
		end

		file_q.delete();
		put_tag(riff);
		put_le($urandom, 4);
		put_tag(wave);
		foreach (plan[i])
			put_chunk(plan[i], odd);
		if (with_data) begin
			put_tag(TAG_DATA);
			put_le(dsize, 4);
			put_noise($urandom_range(0, 3));
		end

		mark_last = (sc != SC_ABANDONED);
		if (sc == SC_TRUNCATED || sc == SC_ABANDONED) begin
			cut = $urandom_range(1, file_q.size() - 1);
			while (file_q.size() > cut)
				void'(file_q.pop_back());
		end
		for (int i = 0; i < file_q.size(); i++)
			send_byte(file_q[i], i == 0, mark_last && i == file_q.size() - 1, 1'b0, ST_OK);
	endtask

	initial begin
		int files_sent;
		int bursts_sent;
		scenario_t sc;
		files_sent = 0;
		bursts_sent = 0;
		clear_parse();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_byte(dir_rows[i].value, dir_rows[i].fb, dir_rows[i].lb,
				dir_rows[i].typed, dir_rows[i].code);

		// each special case once in turn, then mostly random files
		live_words = 0;
		while (live_words < 1400) begin
			set_idling((files_sent / 5) % 4);
			if (files_sent <= SC_ABANDONED)
				sc = scenario_t'(files_sent);
			else if ($urandom_range(9) < 7)
				sc = SC_RANDOM;
			else
				sc = scenario_t'($urandom_range(0, SC_ABANDONED));
			send_file(sc);
			files_sent++;
			if ($urandom_range(4) == 0) begin
				bursts_sent++;
				for (int i = $urandom_range(1, 5); i > 0; i--)
					send_byte(8'($urandom), $urandom_range(3) == 0,
						$urandom_range(3) == 0, 1'b0, ST_OK);
			end
		end
		byte_valid <= 1'b0;
		set_idling(0);

		for (int n = 0; n < 2000 && awaited_headers.size() != 0; n++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (awaited_headers.size() != 0) begin
			if (mismatches < 10)
				$display("%0d header results never arrived", awaited_headers.size());
			mismatches += awaited_headers.size();
		end

		$display("Parsed %0d files (%0d live words after the directed table), %0d noise bursts",
			files_sent, live_words, bursts_sent);
		$display("Headers seen: %0d clean, %0d with an error status; %0d mismatches",
			clean_seen, error_seen, mismatches);
		if (mismatches == 0)
			$display("wav_header_parser test passed");
		else
			$display("wav_header_parser test failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/wavhdr_pkg.sv
rtl/wavhdr_step.sv
rtl/wav_header_parser.sv
sim/wav_header_parser_tb.sv
